>>> sv/rsasc_pkg.sv
// Shared constants, types and helper functions for the radix string
// add/subtract/compare block. No dependencies.

package rsasc_pkg;

    // Operand width; arithmetic wraps modulo 2^VALUE_WIDTH.
    localparam int VALUE_WIDTH = 32;

    // Result digit scratch store.
    localparam int DIGIT_SLOTS = 32;
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);
    localparam int CNT_W       = IDX_W + 1;

    // Divider: quotient bits retired per cycle and resulting cycle count.
    localparam int DIV_STEP  = 4;
    localparam int DIV_CYC   = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W     = DIV_CYC * DIV_STEP;
    localparam int DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Action codes.
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_CMP = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Emission radix limits.
    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_START,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } t_state;

    // Maps a digit value 0..15 to its character.
    function automatic logic [7:0] digit_to_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {4'd0, d};
        end else begin
            ch = CH_SEVEN + {4'd0, d};
        end
        return ch;
    endfunction

endpackage

>>> sv/rsasc_div.sv
// Iterative divider of an operand by a small radix, several quotient bits a cycle.
// Depends on rsasc_pkg.

module rsasc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rsasc_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  logic [4:0]                       i_divisor,
    output logic                             o_done,
    output logic [rsasc_pkg::VALUE_WIDTH-1:0] o_quotient,
    output logic [3:0]                       o_remainder
);
    import rsasc_pkg::*;

    logic [DIV_W-1:0]     r_q;
    logic [DIV_W-1:0]     n_q;
    logic [3:0]           r_rem;
    logic [3:0]           n_rem;
    logic [DIV_CNT_W-1:0] r_step;
    logic                 r_busy;
    logic                 r_done;

    // Restoring long division, DIV_STEP bits per cycle.  The partial
    // remainder stays below the divisor, so five bits hold each trial.
    always_comb begin
        logic [4:0]       trial;
        logic [DIV_W-1:0] q;
        logic [3:0]       rem;
        q   = r_q;
        rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {rem, q[DIV_W-1]};
            if (trial >= i_divisor) begin
                trial = trial - i_divisor;
                q     = {q[DIV_W-2:0], 1'b1};
            end else begin
                q     = {q[DIV_W-2:0], 1'b0};
            end
            rem = trial[3:0];
        end
        n_q   = q;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= DIV_CNT_W'(DIV_CYC - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= DIV_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

>>> sv/rsasc_acc.sv
// Operand accumulators: one shared multiply-accumulate by Horner's rule.
// Depends on rsasc_pkg.

module rsasc_acc (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic                             i_sel,
    input  logic [7:0]                       i_digit_char,
    input  logic [4:0]                       i_digit_base,
    input  logic                             i_final,
    output logic [rsasc_pkg::VALUE_WIDTH-1:0] o_first_value,
    output logic [rsasc_pkg::VALUE_WIDTH-1:0] o_second_value,
    output logic [4:0]                       o_emit_base
);
    import rsasc_pkg::*;

    logic [VALUE_WIDTH-1:0] r_first;
    logic [VALUE_WIDTH-1:0] r_second;
    logic [4:0]             r_first_radix;
    logic [4:0]             r_second_radix;
    logic                   r_first_busy;
    logic                   r_second_busy;
    logic [VALUE_WIDTH-1:0] digit_val;
    logic [VALUE_WIDTH-1:0] mac_in;
    logic [VALUE_WIDTH-1:0] prod;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [4:0]             big_radix;

    always_comb begin
        if (i_digit_char inside {[CH_A:CH_F]}) begin
            digit_val = VALUE_WIDTH'(i_digit_char - CH_SEVEN);
        end else begin
            digit_val = VALUE_WIDTH'(i_digit_char) - VALUE_WIDTH'(CH_ZERO);
        end
        mac_in = i_sel ? r_second : r_first;
        prod   = mac_in * VALUE_WIDTH'(i_digit_base);
        if (i_sel ? r_second_busy : r_first_busy) begin
            n_value = prod + digit_val;
        end else begin
            n_value = digit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first        <= '0;
            r_second       <= '0;
            r_first_radix  <= BASE_MIN;
            r_second_radix <= BASE_MIN;
            r_first_busy   <= 1'b0;
            r_second_busy  <= 1'b0;
        end else if (i_load) begin
            if (i_sel) begin
                r_second       <= n_value;
                r_second_radix <= i_digit_base;
                r_second_busy  <= !i_final;
            end else begin
                r_first        <= n_value;
                r_first_radix  <= i_digit_base;
                r_first_busy   <= !i_final;
            end
        end
    end

    always_comb begin
        big_radix = (r_first_radix > r_second_radix) ? r_first_radix : r_second_radix;
        if (big_radix < BASE_MIN) begin
            o_emit_base = BASE_MIN;
        end else if (big_radix > BASE_MAX) begin
            o_emit_base = BASE_MAX;
        end else begin
            o_emit_base = big_radix;
        end
    end

    assign o_first_value  = r_first;
    assign o_second_value = r_second;

endmodule

>>> sv/radix_string_add_sub_compare.sv
// Top level of the radix string add/subtract/compare block: sequencer,
// result digit store and output register. Depends on rsasc_pkg, rsasc_acc
// and rsasc_div.
//
// Usage: digit requests arrive on the slave stream, most significant digit
// first; tuser selects the operand and tlast marks an operand's final digit.
// Each digit is folded into its operand in the cycle it is accepted, so,
// while the sequencer is idle, a run of digits streams in at one request
// per cycle.  The final digit of the second operand triggers the action:
// compare gives one result request with the less/equal/greater flags once
// evaluation has loaded the output register; add and subtract produce the
// result in the larger radix, a leading '-' when negative.  Each add or
// subtract result digit costs one pass of the shared divider, ST_START then
// ST_DIV, for up to 32 digits; each character is then read back from the
// digit store through ST_READ and ST_EMIT, most significant first.  Input
// is not ready from the triggering request until the last result character
// has been loaded.  One output register parts the two sides; when the
// receiver stalls, the sequencer simply holds until the register is free.
// Reset clears both operands to zero, their radixes to two and returns the
// sequencer to idle; the digit store needs no clearing.

module radix_string_add_sub_compare (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0 up: action[1:0], digit_char[9:2], digit_base[14:10], zero.
    input  logic [rsasc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // Fields: operand_sel[0].
    input  logic                             i_s_tuser,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0 up: out_char[7:0], is_less[8], is_equal[9],
    // is_greater[10], zeros[15:11].
    output logic [rsasc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready
);
    import rsasc_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [1:0]             r_action;
    logic [1:0]             n_action;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic                   r_neg;
    logic                   n_neg;
    logic [4:0]             r_base;
    logic [4:0]             n_base;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [3:0]             r_rd_data;
    logic [3:0]             mem [DIGIT_SLOTS];
    logic                   mem_we;

    logic                   r_ov;
    logic                   n_ov;
    logic [7:0]             r_o_char;
    logic [7:0]             n_o_char;
    logic [2:0]             r_o_flags;
    logic [2:0]             n_o_flags;
    logic                   r_o_last;
    logic                   n_o_last;

    logic                   s_accept;
    logic                   trigger;
    logic [1:0]             in_action;
    logic [7:0]             in_char;
    logic [4:0]             in_base;
    logic [VALUE_WIDTH-1:0] first_value;
    logic [VALUE_WIDTH-1:0] second_value;
    logic [4:0]             emit_base;
    logic [VALUE_WIDTH-1:0] result;
    logic                   can_load;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [3:0]             div_rem;

    assign in_action = i_s_tdata[1:0];
    assign in_char   = i_s_tdata[9:2];
    assign in_base   = i_s_tdata[14:10];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    // Only the final digit of the second operand with a defined action
    // starts a result; everything else just accumulates.
    assign trigger    = i_s_tuser && i_s_tlast &&
                        (in_action inside {ACT_ADD, ACT_SUB, ACT_CMP});
    assign can_load   = !r_ov || i_m_tready;

    rsasc_acc u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (s_accept),
        .i_sel          (i_s_tuser),
        .i_digit_char   (in_char),
        .i_digit_base   (in_base),
        .i_final        (i_s_tlast),
        .o_first_value  (first_value),
        .o_second_value (second_value),
        .o_emit_base    (emit_base)
    );

    rsasc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    assign result = (r_action == ACT_SUB) ? (first_value - second_value)
                                          : (first_value + second_value);

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_base    = r_base;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_ov      = r_ov && !i_m_tready;
        n_o_char  = r_o_char;
        n_o_flags = r_o_flags;
        n_o_last  = r_o_last;
        div_start = 1'b0;
        mem_we    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_accept && trigger) begin
                    n_action = in_action;
                    n_state  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_action == ACT_CMP) begin
                    if (can_load) begin
                        n_ov      = 1'b1;
                        n_o_char  = 8'd0;
                        n_o_flags = {$signed(first_value) > $signed(second_value),
                                     first_value == second_value,
                                     $signed(first_value) < $signed(second_value)};
                        n_o_last  = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    // The most negative value negates to itself, which read
                    // unsigned is exactly its magnitude.
                    n_neg   = result[VALUE_WIDTH-1];
                    n_mag   = result[VALUE_WIDTH-1] ? (~result + 1'b1) : result;
                    n_base  = emit_base;
                    n_cnt   = '0;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                // Digits are stored least significant first; a zero
                // magnitude still yields one '0' digit.
                if (div_done) begin
                    mem_we = 1'b1;
                    n_mag  = div_quot;
                    n_cnt  = r_cnt + 1'b1;
                    if (div_quot == '0 || r_cnt == CNT_W'(DIGIT_SLOTS - 1)) begin
                        n_idx   = r_cnt[IDX_W-1:0];
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_SIGN: begin
                if (!r_neg) begin
                    n_state = ST_READ;
                end else if (can_load) begin
                    n_ov      = 1'b1;
                    n_o_char  = CH_MINUS;
                    n_o_flags = 3'b000;
                    n_o_last  = 1'b0;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (can_load) begin
                    n_ov      = 1'b1;
                    n_o_char  = digit_to_char(r_rd_data);
                    n_o_flags = 3'b000;
                    n_o_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_base    <= n_base;
        r_idx     <= n_idx;
        r_o_char  <= n_o_char;
        r_o_flags <= n_o_flags;
        r_o_last  <= n_o_last;
    end

    // Digit store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[IDX_W-1:0]] <= div_rem;
        end
        r_rd_data <= mem[r_idx];
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(M_TDATA_W - 11)'(0), r_o_flags, r_o_char};
    assign o_m_tlast  = r_o_last;

    // A triggering request always leads straight into evaluation.
    a_trigger_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && trigger) |=> (r_state == ST_EVAL))
        else $error("trigger request did not start evaluation");

    // The divider's remainder is a valid digit of the emission radix.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_done) |-> (div_rem < r_base))
        else $error("divider remainder not below the radix");

    // The digit count never passes the store's depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DIGIT_SLOTS))
        else $error("digit count beyond store depth");

    // Characters are read back only after at least one digit was stored.
    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("emitting with an empty digit store");

    // The divider is started only from ST_START, which always moves on into ST_DIV.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV))
        else $error("divider started outside the digit loop");

endmodule
